// ----- rtl/prq_pkg.sv -----
`default_nettype none
package prq_pkg;

   localparam int SLOTS            = 16;
   localparam int MAX_PACKET_BYTES = 64;

   localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int BIDX_W  = (MAX_PACKET_BYTES > 1) ? $clog2(MAX_PACKET_BYTES) : 1;
   localparam int ADDR_W  = SLOT_W + BIDX_W;
   localparam int RAM_DEPTH = SLOTS * (2 ** BIDX_W);
   localparam int OCC_W   = $clog2(SLOTS + 1);
   localparam int LEN_W   = 7;
   localparam int CFG_W   = 5;
   localparam int PADDR_W = 3;
   localparam int PEND_W  = 2;

   localparam logic [1:0] MODE_APPEND  = 2'd0;
   localparam logic [1:0] MODE_COMMIT  = 2'd1;
   localparam logic [1:0] MODE_DEQUEUE = 2'd2;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_FULL      = 3'd1;
   localparam logic [2:0] ST_EMPTY     = 3'd2;
   localparam logic [2:0] ST_TOO_LONG  = 3'd3;
   localparam logic [2:0] ST_CAP_SHORT = 3'd4;
   localparam logic [2:0] ST_ZERO_CAP  = 3'd5;

   localparam logic [PADDR_W-1:0] REG_SLOTS_IN_USE = '0;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  data_byte;
      logic [31:0] session_tag;
      logic [31:0] action_word;
      logic [6:0]  out_capacity;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic        byte_valid;
      logic [7:0]  out_byte;
      logic        last_result;
      logic [6:0]  packet_length;
      logic [31:0] out_session;
      logic [31:0] out_action;
   } rsp_type;

   typedef struct packed {
      logic [2:0]        status;
      logic [SLOT_W-1:0] slot;
      logic [LEN_W-1:0]  len;
      logic [31:0]       session;
      logic [31:0]       action;
   } job_type;

   function automatic logic [OCC_W-1:0] active_slots(input logic [CFG_W-1:0] value);
      logic [OCC_W-1:0] n;
      if (value == '0) begin
         n = OCC_W'(1);
      end else if (int'(value) > SLOTS) begin
         n = OCC_W'(SLOTS);
      end else begin
         n = OCC_W'(value);
      end
      return n;
   endfunction

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] idx,
                                                   input logic [OCC_W-1:0] active);
      logic [OCC_W:0] n;
      logic [SLOT_W-1:0] r;
      n = (OCC_W+1)'(idx) + (OCC_W+1)'(1);
      if (n >= {1'b0, active}) begin
         r = '0;
      end else begin
         r = SLOT_W'(n);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/prq_ram.sv -----
`default_nettype none
module prq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ----- rtl/prq_job_fifo.sv -----
`default_nettype none
module prq_job_fifo
   import prq_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   input  wire logic    pop,
   output job_type      head,
   output logic         full,
   output logic         empty
);

   job_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/prq_front.sv -----
`default_nettype none
module prq_front
   import prq_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire req_type          req_payload,
   input  wire logic [OCC_W-1:0] active,
   input  wire logic             fifo_full,
   input  wire logic             stream_done,
   output logic                  busy,
   output logic                  push,
   output job_type               push_job,
   output logic                  ram_we,
   output logic [ADDR_W-1:0]     ram_waddr,
   output logic [7:0]            ram_wdata
);

   logic [SLOT_W-1:0] wr_idx_ff, wr_idx_in;
   logic [SLOT_W-1:0] rd_idx_ff, rd_idx_in;
   logic [OCC_W-1:0]  occ_ff, occ_in;
   logic [LEN_W-1:0]  fill_ff, fill_in;
   logic              overlong_ff, overlong_in;
   logic              lost_ff, lost_in;
   logic [PEND_W-1:0] pend_ff, pend_in;

   logic [LEN_W-1:0]  meta_len_ff [SLOTS];
   logic [31:0]       meta_sess_ff [SLOTS];
   logic [31:0]       meta_act_ff [SLOTS];

   logic              take;
   logic              hazard;
   logic              meta_we;
   logic              pend_inc;
   logic [LEN_W-1:0]  cur_len_raw;
   logic [LEN_W-1:0]  cur_len;

   assign hazard = (pend_ff != '0) &&
                   (({1'b0, occ_ff} + (OCC_W+1)'(pend_ff)) >= {1'b0, active});
   assign busy   = fifo_full || hazard;
   assign take   = start && !busy;

   assign cur_len_raw = meta_len_ff[rd_idx_ff];
   assign cur_len     = (cur_len_raw > LEN_W'(MAX_PACKET_BYTES)) ?
                        LEN_W'(MAX_PACKET_BYTES) : cur_len_raw;

   assign ram_waddr = {wr_idx_ff, fill_ff[BIDX_W-1:0]};
   assign ram_wdata = req_payload.data_byte;

   always_comb begin
      wr_idx_in   = wr_idx_ff;
      rd_idx_in   = rd_idx_ff;
      occ_in      = occ_ff;
      fill_in     = fill_ff;
      overlong_in = overlong_ff;
      lost_in     = lost_ff;
      ram_we      = 1'b0;
      meta_we     = 1'b0;
      push        = 1'b0;
      pend_inc    = 1'b0;
      push_job    = '0;
      if (take) begin
         unique case (req_payload.mode)
            MODE_APPEND: begin
               if (fill_ff >= LEN_W'(MAX_PACKET_BYTES)) begin
                  overlong_in = 1'b1;
               end else begin
                  if (occ_ff >= active) begin
                     lost_in = 1'b1;
                  end else begin
                     ram_we = 1'b1;
                  end
                  fill_in = fill_ff + LEN_W'(1);
               end
            end
            MODE_COMMIT: begin
               push = 1'b1;
               if (overlong_ff) begin
                  push_job.status = ST_TOO_LONG;
               end else if (lost_ff || occ_ff >= active) begin
                  push_job.status = ST_FULL;
               end else begin
                  push_job.status = ST_OK;
                  meta_we         = 1'b1;
                  wr_idx_in       = next_slot(wr_idx_ff, active);
                  occ_in          = occ_ff + OCC_W'(1);
               end
               fill_in     = '0;
               overlong_in = 1'b0;
               lost_in     = 1'b0;
            end
            MODE_DEQUEUE: begin
               push = 1'b1;
               if (req_payload.out_capacity == '0) begin
                  push_job.status = ST_ZERO_CAP;
               end else if (occ_ff == '0) begin
                  push_job.status = ST_EMPTY;
               end else if (req_payload.out_capacity < cur_len) begin
                  push_job.status = ST_CAP_SHORT;
               end else begin
                  push_job.status  = ST_OK;
                  push_job.slot    = rd_idx_ff;
                  push_job.len     = cur_len;
                  push_job.session = meta_sess_ff[rd_idx_ff];
                  push_job.action  = meta_act_ff[rd_idx_ff];
                  rd_idx_in        = next_slot(rd_idx_ff, active);
                  occ_in           = occ_ff - OCC_W'(1);
                  pend_inc         = (cur_len != '0);
               end
            end
            default: begin
            end
         endcase
      end
      pend_in = pend_ff + PEND_W'(pend_inc) - PEND_W'(stream_done);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff   <= '0;
         rd_idx_ff   <= '0;
         occ_ff      <= '0;
         fill_ff     <= '0;
         overlong_ff <= 1'b0;
         lost_ff     <= 1'b0;
         pend_ff     <= '0;
      end else begin
         wr_idx_ff   <= wr_idx_in;
         rd_idx_ff   <= rd_idx_in;
         occ_ff      <= occ_in;
         fill_ff     <= fill_in;
         overlong_ff <= overlong_in;
         lost_ff     <= lost_in;
         pend_ff     <= pend_in;
      end
      if (meta_we) begin
         meta_len_ff[wr_idx_ff]  <= fill_ff;
         meta_sess_ff[wr_idx_ff] <= req_payload.session_tag;
         meta_act_ff[wr_idx_ff]  <= req_payload.action_word;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/prq_back.sv -----
`default_nettype none
module prq_back
   import prq_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          fifo_empty,
   input  wire job_type       head,
   input  wire logic [7:0]    ram_rdata,
   output logic               pop,
   output logic               ram_re,
   output logic [ADDR_W-1:0]  ram_raddr,
   output logic               stream_done,
   output logic               rsp_valid,
   output rsp_type            rsp_payload
);

   logic              stream_ff, stream_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [LEN_W-1:0]  idx_ff, idx_in;
   logic [31:0]       sess_ff, sess_in;
   logic [31:0]       act_ff, act_in;
   logic              valid_ff, valid_in;
   rsp_type           out_ff, out_in;
   logic              last_byte;

   assign pop       = !stream_ff && !fifo_empty;
   assign ram_raddr = {slot_ff, idx_ff[BIDX_W-1:0]};
   assign ram_re    = stream_ff;
   assign last_byte = (idx_ff == (len_ff - LEN_W'(1)));
   assign stream_done = stream_ff && last_byte;

   always_comb begin
      stream_in = stream_ff;
      slot_in   = slot_ff;
      len_in    = len_ff;
      idx_in    = idx_ff;
      sess_in   = sess_ff;
      act_in    = act_ff;
      valid_in  = 1'b0;
      out_in    = out_ff;
      if (stream_ff) begin
         valid_in             = 1'b1;
         out_in.status        = ST_OK;
         out_in.byte_valid    = 1'b1;
         out_in.out_byte      = '0;
         out_in.last_result   = last_byte;
         out_in.packet_length = len_ff;
         out_in.out_session   = sess_ff;
         out_in.out_action    = act_ff;
         idx_in               = idx_ff + LEN_W'(1);
         if (last_byte) begin
            stream_in = 1'b0;
         end
      end else if (pop) begin
         if (head.status == ST_OK && head.len != '0) begin
            stream_in = 1'b1;
            slot_in   = head.slot;
            len_in    = head.len;
            idx_in    = '0;
            sess_in   = head.session;
            act_in    = head.action;
         end else begin
            valid_in             = 1'b1;
            out_in.status        = head.status;
            out_in.byte_valid    = 1'b0;
            out_in.out_byte      = '0;
            out_in.last_result   = 1'b1;
            out_in.packet_length = head.len;
            out_in.out_session   = head.session;
            out_in.out_action    = head.action;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stream_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         stream_ff <= stream_in;
         valid_ff  <= valid_in;
      end
      slot_ff <= slot_in;
      len_ff  <= len_in;
      idx_ff  <= idx_in;
      sess_ff <= sess_in;
      act_ff  <= act_in;
      out_ff  <= out_in;
   end

   always_comb begin
      rsp_payload          = out_ff;
      rsp_payload.out_byte = out_ff.byte_valid ? ram_rdata : 8'd0;
   end

   assign rsp_valid = valid_ff;

endmodule
`default_nettype wire

// ----- rtl/packet_ring_queue.sv -----
`default_nettype none
// Packet ring queue. An append, commit or dequeue is taken when start is high and busy
// is low. Commits and dequeues post a job
// to a two-entry queue that the output side drains; a rejected or empty dequeue and
// every commit give one result, a good dequeue gives one result per byte, one per
// cycle, once the output side has loaded the job. busy rises while the job queue
// is full, or while the slot under write may still be read by a packet on its way
// out. rsp_valid marks each result for exactly one cycle and there is no way to
// hold it off.
module packet_ring_queue
   import prq_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire req_type            req_payload,
   output logic                    rsp_valid,
   output rsp_type                 rsp_payload,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);

   logic [CFG_W-1:0]  slots_ff, slots_in;
   logic [OCC_W-1:0]  active;
   logic              cfg_hit;

   logic              push, pop, fifo_full, fifo_empty;
   job_type           push_job, head;
   logic              stream_done;
   logic              ram_we, ram_re;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [7:0]        ram_wdata, ram_rdata;

   assign pready  = 1'b1;
   assign cfg_hit = (paddr[PADDR_W-1:2] == REG_SLOTS_IN_USE[PADDR_W-1:2]);
   assign prdata  = cfg_hit ? 32'(slots_ff) : 32'd0;
   assign active  = active_slots(slots_ff);

   always_comb begin
      slots_in = slots_ff;
      if (psel && penable && pwrite && pready && cfg_hit) begin
         slots_in = pwdata[CFG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_ff <= CFG_W'(SLOTS);
      end else begin
         slots_ff <= slots_in;
      end
   end

   prq_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_payload (req_payload),
      .active      (active),
      .fifo_full   (fifo_full),
      .stream_done (stream_done),
      .busy        (busy),
      .push        (push),
      .push_job    (push_job),
      .ram_we      (ram_we),
      .ram_waddr   (ram_waddr),
      .ram_wdata   (ram_wdata)
   );

   prq_job_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .full     (fifo_full),
      .empty    (fifo_empty)
   );

   prq_ram #(
      .WIDTH (8),
      .DEPTH (RAM_DEPTH)
   ) u_payload (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   prq_back u_back (
      .clock       (clock),
      .reset       (reset),
      .fifo_empty  (fifo_empty),
      .head        (head),
      .ram_rdata   (ram_rdata),
      .pop         (pop),
      .ram_re      (ram_re),
      .ram_raddr   (ram_raddr),
      .stream_done (stream_done),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

// ----- tb/sv/packet_ring_queue_tb.sv -----
`default_nettype none
module packet_ring_queue_tb
   import prq_pkg::*;
();

   localparam logic [1:0]         MODE_UNUSED   = 2'd3;
   localparam logic [PADDR_W-1:0] UNMAPPED_ADDR = PADDR_W'(4);
   localparam int unsigned        CYCLE_LIMIT   = 400_000;
   localparam int unsigned        SETTLE_CYCLES = 100;
   localparam int unsigned        PHASE_ITEMS   = 5;

   class prq_scoreboard;
      logic [7:0]        payload_mem [SLOTS*MAX_PACKET_BYTES];
      logic [LEN_W-1:0]  slot_len [SLOTS];
      logic [31:0]       slot_sess [SLOTS];
      logic [31:0]       slot_act [SLOTS];
      int unsigned       rd_idx, wr_idx, occ, fill;
      bit                overlong, lost;
      logic [CFG_W-1:0]  slots_reg;
      rsp_type           due_results[$];
      int unsigned       errors, items, checked;
      int unsigned       status_hits [8];

      function new();
         slots_reg = CFG_W'(SLOTS);
      endfunction

      function int unsigned active();
         int unsigned n;
         n = 32'(slots_reg);
         if (n == 0) n = 1;
         if (n > SLOTS) n = SLOTS;
         return n;
      endfunction

      function int unsigned step_index(int unsigned idx);
         int unsigned n;
         n = idx + 1;
         if (n >= active() || n >= SLOTS) n = 0;
         return n;
      endfunction

      function void write_reg(logic [PADDR_W-1:0] addr, logic [31:0] value);
         if (addr == REG_SLOTS_IN_USE) slots_reg = value[CFG_W-1:0];
      endfunction

      function void post(logic [2:0] code, logic valid, logic [7:0] data, logic last,
                         logic [6:0] len, logic [31:0] sess, logic [31:0] act);
         rsp_type p;
         p.status        = code;
         p.byte_valid    = valid;
         p.out_byte      = data;
         p.last_result   = last;
         p.packet_length = len;
         p.out_session   = sess;
         p.out_action    = act;
         due_results.push_back(p);
      endfunction

      function void apply_item(req_type t);
         int unsigned r, len, i;
         logic [2:0]  code;
         items++;
         case (t.mode)
            MODE_APPEND: begin
               if (fill >= MAX_PACKET_BYTES) begin
                  overlong = 1'b1;
               end else if (occ >= active()) begin
                  lost = 1'b1;
                  fill++;
               end else begin
                  payload_mem[wr_idx*MAX_PACKET_BYTES + fill] = t.data_byte;
                  fill++;
               end
            end
            MODE_COMMIT: begin
               if (overlong) begin
                  code = ST_TOO_LONG;
               end else if (lost || occ >= active()) begin
                  code = ST_FULL;
               end else begin
                  slot_len[wr_idx]  = LEN_W'(fill);
                  slot_sess[wr_idx] = t.session_tag;
                  slot_act[wr_idx]  = t.action_word;
                  wr_idx = step_index(wr_idx);
                  occ++;
                  code = ST_OK;
               end
               fill     = 0;
               overlong = 1'b0;
               lost     = 1'b0;
               post(code, 1'b0, 8'h00, 1'b1, 7'd0, 32'h0, 32'h0);
            end
            MODE_DEQUEUE: begin
               if (t.out_capacity == 0) begin
                  post(ST_ZERO_CAP, 1'b0, 8'h00, 1'b1, 7'd0, 32'h0, 32'h0);
               end else if (occ == 0) begin
                  post(ST_EMPTY, 1'b0, 8'h00, 1'b1, 7'd0, 32'h0, 32'h0);
               end else begin
                  r   = rd_idx;
                  len = 32'(slot_len[r]);
                  if (t.out_capacity < len) begin
                     post(ST_CAP_SHORT, 1'b0, 8'h00, 1'b1, 7'd0, 32'h0, 32'h0);
                  end else begin
                     rd_idx = step_index(r);
                     occ--;
                     if (len == 0) begin
                        post(ST_OK, 1'b0, 8'h00, 1'b1, 7'd0, slot_sess[r], slot_act[r]);
                     end else begin
                        for (i = 0; i < len; i++) begin
                           post(ST_OK, 1'b1, payload_mem[r*MAX_PACKET_BYTES + i],
                                (i + 1 == len), LEN_W'(len), slot_sess[r], slot_act[r]);
                        end
                     end
                  end
               end
            end
            default: ;
         endcase
      endfunction

      function void flag(string name, logic [31:0] e, logic [31:0] a);
         if (a !== e) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, e, a);
            errors++;
         end
      endfunction

      function void match_result(rsp_type got);
         rsp_type e;
         if (due_results.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %h", $time, got);
            errors++;
            return;
         end
         e = due_results.pop_front();
         checked++;
         status_hits[e.status]++;
         flag("status", 32'(e.status), 32'(got.status));
         flag("byte_valid", 32'(e.byte_valid), 32'(got.byte_valid));
         flag("out_byte", 32'(e.out_byte), 32'(got.out_byte));
         flag("last_result", 32'(e.last_result), 32'(got.last_result));
         flag("packet_length", 32'(e.packet_length), 32'(got.packet_length));
         flag("out_session", e.out_session, got.out_session);
         flag("out_action", e.out_action, got.out_action);
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   req_type            req_payload = '0;
   logic               rsp_valid;
   rsp_type            rsp_payload;
   logic               psel = 1'b0;
   logic               penable = 1'b0;
   logic               pwrite = 1'b0;
   logic [PADDR_W-1:0] paddr = '0;
   logic [31:0]        pwdata = '0;
   logic [31:0]        prdata;
   logic               pready;

   prq_scoreboard sb;
   int unsigned   idle_pct;
   int unsigned   cycle_count = 0;

   packet_ring_queue i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1) begin
         sb.match_result(rsp_payload);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("packet_ring_queue regression: fail");
         $finish;
      end
   end

   function automatic req_type random_req(logic [1:0] mode);
      req_type t;
      t.mode         = mode;
      t.data_byte    = 8'($urandom);
      t.session_tag  = $urandom;
      t.action_word  = $urandom;
      t.out_capacity = 7'($urandom);
      return t;
   endfunction

   task automatic send(input req_type t);
      start       <= 1'b1;
      req_payload <= t;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      sb.apply_item(t);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic append_bytes(input int unsigned count);
      repeat (count) send(random_req(MODE_APPEND));
   endtask

   task automatic append_byte(input logic [7:0] data);
      req_type t;
      t = random_req(MODE_APPEND);
      t.data_byte = data;
      send(t);
   endtask

   task automatic commit(input logic [31:0] tag, input logic [31:0] act);
      req_type t;
      t = random_req(MODE_COMMIT);
      t.session_tag = tag;
      t.action_word = act;
      send(t);
   endtask

   task automatic dequeue(input logic [6:0] cap);
      req_type t;
      t = random_req(MODE_DEQUEUE);
      t.out_capacity = cap;
      send(t);
   endtask

   task automatic settle();
      start <= 1'b0;
      while (sb.due_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic drain();
      commit($urandom, $urandom);
      while (sb.occ != 0) dequeue(7'(MAX_PACKET_BYTES));
      settle();
   endtask

   task automatic csr_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (pready !== 1'b1) @(posedge clock);
      sb.write_reg(addr, data);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_check(input logic [PADDR_W-1:0] addr);
      logic [31:0] want;
      want = {{(32-CFG_W){1'b0}}, sb.slots_reg};
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (pready !== 1'b1) @(posedge clock);
      if (prdata !== want) begin
         $display("%0t: register read mismatch, expected %h actual %h", $time, want, prdata);
         sb.errors++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_phase(input int unsigned budget);
      int unsigned sent, pick, len, head;
      logic [6:0]  cap;
      sent = 0;
      while (sent < budget) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            len = $urandom_range(0, 6);
            append_bytes(len);
            if ($urandom_range(0, 9) != 0) commit($urandom, $urandom);
            sent += len + 1;
         end else if (pick < 85) begin
            if (sb.occ == 0) begin
               cap = ($urandom_range(0, 2) == 0) ? 7'd0 : 7'($urandom_range(1, 127));
            end else begin
               head = 32'(sb.slot_len[sb.rd_idx]);
               case ($urandom_range(0, 5))
                  0: cap = (head == 0) ? 7'd1 : 7'(head);
                  1: cap = (head == 0) ? 7'd0 : 7'(head - 1);
                  2: cap = 7'(MAX_PACKET_BYTES);
                  3: cap = 7'd127;
                  4: cap = 7'($urandom_range(0, 127));
                  default: cap = 7'($urandom_range(head, MAX_PACKET_BYTES));
               endcase
            end
            dequeue(cap);
            sent++;
         end else if (pick < 95) begin
            commit($urandom, $urandom);
            sent++;
         end else begin
            send(random_req(MODE_UNUSED));
         end
      end
      drain();
   endtask

   initial begin
      sb = new();
      idle_pct = 36;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      csr_write(REG_SLOTS_IN_USE, 32'(SLOTS));
      csr_check(REG_SLOTS_IN_USE);
      dequeue(7'd0);
      dequeue(7'(MAX_PACKET_BYTES));
      commit(32'h0000_0000, 32'hFFFF_FFFF);
      dequeue(7'd1);
      send(random_req(MODE_UNUSED));
      append_byte(8'h00);
      append_byte(8'hFF);
      append_bytes(1);
      commit(32'hFFFF_FFFF, 32'h0000_0000);
      dequeue(7'd2);
      dequeue(7'd3);
      settle();

      // single slot: full-size packet, full ring, dropped bytes, too long over full
      csr_write(REG_SLOTS_IN_USE, 32'd1);
      csr_check(REG_SLOTS_IN_USE);
      append_bytes(MAX_PACKET_BYTES);
      commit($urandom, $urandom);
      commit($urandom, $urandom);
      append_bytes(2);
      commit($urandom, $urandom);
      append_bytes(MAX_PACKET_BYTES + 1);
      commit($urandom, $urandom);
      dequeue(7'(MAX_PACKET_BYTES - 1));
      dequeue(7'd127);
      dequeue(7'(MAX_PACKET_BYTES));
      settle();

      idle_pct = 45;
      csr_write(REG_SLOTS_IN_USE, 32'hFFFF_FFFF);
      csr_write(UNMAPPED_ADDR, $urandom);
      csr_check(REG_SLOTS_IN_USE);
      random_phase(PHASE_ITEMS);

      idle_pct = 0;
      csr_write(REG_SLOTS_IN_USE, 32'h0000_0000);
      csr_check(REG_SLOTS_IN_USE);
      random_phase(PHASE_ITEMS);

      csr_write(REG_SLOTS_IN_USE, 32'd5);
      csr_check(REG_SLOTS_IN_USE);
      random_phase(PHASE_ITEMS);

      $display("covered %0d transactions and %0d results over ring sizes 16, 1, 31, 0, 5",
               sb.items, sb.checked);
      $display("status mix: ok %0d full %0d empty %0d too_long %0d cap_short %0d zero_cap %0d",
               sb.status_hits[ST_OK], sb.status_hits[ST_FULL], sb.status_hits[ST_EMPTY],
               sb.status_hits[ST_TOO_LONG], sb.status_hits[ST_CAP_SHORT],
               sb.status_hits[ST_ZERO_CAP]);
      if (sb.errors == 0 && sb.due_results.size() == 0) begin
         $display("packet_ring_queue regression: pass");
      end else begin
         $display("packet_ring_queue regression: fail");
      end
      $finish;
   end

endmodule
`default_nettype wire

// ----- packet_ring_queue.f -----
rtl/prq_pkg.sv
rtl/prq_ram.sv
rtl/prq_job_fifo.sv
rtl/prq_front.sv
rtl/prq_back.sv
rtl/packet_ring_queue.sv
tb/sv/packet_ring_queue_tb.sv
